>>> hw/rtl/aleg_pkg.sv
// shared types, constants and codes of the associated legendre evaluator
package aleg_pkg;

  // fixed field widths
  localparam int BAND_W = 3;
  localparam int ARG_W  = 18;
  localparam int VAL_W  = 40;
  // operand a of the shared unit: one bit over a value, holds a difference of two values
  localparam int OPA_W  = VAL_W + 1;

  // degree and order clamp
  localparam int MAX_BAND = 7;

  // default fraction bits
  localparam int FRAC_BITS_DEF = 16;

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_MUL_RAW,
    OP_MUL_Q,
    OP_DIV,
    OP_SQRT
  } alu_op_e;

  typedef enum logic [1:0] {
    A_IDLE,
    A_RUN,
    A_FIN
  } alu_state_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQR,
    S_SQRT,
    S_MM_RAW,
    S_MM_Q,
    S_M1_RAW,
    S_M1_Q,
    S_RC_A1,
    S_RC_A2,
    S_RC_B,
    S_RC_DIV,
    S_OUT
  } seq_state_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

endpackage

>>> hw/rtl/aleg_unit.sv
// shared iterative unit: chunked multiply, small divide and square root
module aleg_unit import aleg_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  alu_req_t                    req_i,
  input  logic signed [OPA_W-1:0]     a_i,
  input  logic signed [FRAC_BITS+1:0] b_i,
  input  logic [2*FRAC_BITS+1:0]      rad_i,
  output logic                        done_o,
  output logic signed [VAL_W-1:0]     res_o,
  output logic [2*FRAC_BITS+1:0]      mag_o
);

  localparam int MBW   = FRAC_BITS + 2;
  localparam int RADW  = 2 * FRAC_BITS + 2;
  localparam int DGW   = 24;
  localparam int NDIG  = 2;
  localparam int OPW   = DGW * NDIG;
  localparam int NBYTE = OPW / 8;
  localparam int SHW   = (RADW > OPW) ? RADW : OPW;
  localparam int ACW   = OPW + MBW;
  localparam int RTW   = FRAC_BITS + 1;
  localparam int RMW   = FRAC_BITS + 4;
  localparam int CNTW  = $clog2(RTW + 1);

  localparam logic [ACW-1:0] HALF    = ACW'(1) << (FRAC_BITS - 1);
  localparam logic [ACW-1:0] LIM_POS = ACW'({(VAL_W-1){1'b1}});
  localparam logic [ACW-1:0] LIM_NEG = LIM_POS + ACW'(1);

  alu_state_e state_q, state_d;
  alu_op_e    op_q, op_d;
  logic       neg_q, neg_d;
  logic       done_q, done_d;
  logic [SHW-1:0]  opa_q, opa_d;
  logic [ACW-1:0]  acc_q, acc_d;
  logic [RMW-1:0]  rem_q, rem_d;
  logic [MBW-1:0]  mb_q, mb_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic signed [VAL_W-1:0] res_q, res_d;

  logic [OPA_W-1:0] ma;
  logic [MBW-1:0]   mb_in;

  // divide step: eight quotient bits
  logic [2:0] dv_r;
  logic [3:0] dv_t;
  logic [7:0] dv_q;
  logic [7:0] dv_byte;

  // square root step
  logic [1:0]     sq_pair;
  logic [RTW-1:0] sq_rt_in, sq_rt;
  logic [RMW-1:0] sq_remx, sq_trial, sq_rem;

  // final rounding and saturation
  logic [ACW-1:0] fin_m, fin_n;
  logic signed [VAL_W-1:0] fin_v;

  assign ma    = a_i[OPA_W-1] ? (~a_i + 1'b1) : a_i;
  assign mb_in = b_i[MBW-1] ? (~b_i + 1'b1) : b_i;

  always_comb begin
    dv_byte = opa_q[SHW-1 -: 8];
    dv_r    = rem_q[2:0];
    dv_t    = '0;
    dv_q    = '0;
    for (int k = 7; k >= 0; k--) begin
      dv_t = {dv_r, dv_byte[k]};
      if (dv_t >= {1'b0, mb_q[2:0]}) begin
        dv_t    = dv_t - {1'b0, mb_q[2:0]};
        dv_q[k] = 1'b1;
      end
      dv_r = dv_t[2:0];
    end
  end

  always_comb begin
    sq_pair  = opa_q[SHW-1 -: 2];
    sq_rt_in = acc_q[RTW-1:0];
    sq_remx  = {rem_q[RMW-3:0], sq_pair};
    sq_trial = RMW'({sq_rt_in, 2'b01});
    if (sq_remx >= sq_trial) begin
      sq_rem = sq_remx - sq_trial;
      sq_rt  = {sq_rt_in[RTW-2:0], 1'b1};
    end else begin
      sq_rem = sq_remx;
      sq_rt  = {sq_rt_in[RTW-2:0], 1'b0};
    end
  end

  always_comb begin
    unique case (op_q)
      OP_MUL_Q: fin_m = (acc_q + HALF) >> FRAC_BITS;
      // round to nearest: step up when the remainder exceeds the root
      OP_SQRT:  fin_m = acc_q + ACW'(rem_q > RMW'(acc_q[RTW-1:0]));
      default:  fin_m = acc_q;
    endcase
    fin_n = ~fin_m + 1'b1;
    if (neg_q) begin
      fin_v = (fin_m > LIM_NEG) ? VAL_MIN : fin_n[VAL_W-1:0];
    end else begin
      fin_v = (fin_m > LIM_POS) ? VAL_MAX : fin_m[VAL_W-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      A_IDLE: begin
        if (req_i.start) state_d = A_RUN;
      end
      A_RUN: begin
        if (cnt_q == CNTW'(1)) state_d = A_FIN;
      end
      A_FIN:   state_d = A_IDLE;
      default: state_d = A_IDLE;
    endcase
  end

  always_comb begin
    op_d   = op_q;
    neg_d  = neg_q;
    opa_d  = opa_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    mb_d   = mb_q;
    cnt_d  = cnt_q;
    res_d  = res_q;
    done_d = 1'b0;
    unique case (state_q)
      A_IDLE: begin
        if (req_i.start) begin
          op_d  = req_i.op;
          mb_d  = mb_in;
          acc_d = '0;
          rem_d = '0;
          unique case (req_i.op)
            OP_SQRT: begin
              neg_d = 1'b0;
              opa_d = SHW'(rad_i) << (SHW - RADW);
              cnt_d = CNTW'(RTW);
            end
            OP_DIV: begin
              neg_d = a_i[OPA_W-1];
              opa_d = SHW'(OPW'(ma)) << (SHW - OPW);
              cnt_d = CNTW'(NBYTE);
            end
            default: begin
              neg_d = a_i[OPA_W-1] ^ b_i[MBW-1];
              opa_d = SHW'(OPW'(ma)) << (SHW - OPW);
              cnt_d = CNTW'(NDIG);
            end
          endcase
        end
      end
      A_RUN: begin
        cnt_d = cnt_q - CNTW'(1);
        unique case (op_q)
          OP_SQRT: begin
            acc_d = ACW'(sq_rt);
            rem_d = sq_rem;
            opa_d = opa_q << 2;
          end
          OP_DIV: begin
            acc_d = {acc_q[ACW-9:0], dv_q};
            rem_d = RMW'(dv_r);
            opa_d = opa_q << 8;
          end
          default: begin
            // most significant digit first
            acc_d = (acc_q << DGW) + ACW'(opa_q[SHW-1 -: DGW]) * ACW'(mb_q);
            opa_d = opa_q << DGW;
          end
        endcase
      end
      A_FIN: begin
        res_d  = fin_v;
        done_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    neg_q <= neg_d;
    opa_q <= opa_d;
    acc_q <= acc_d;
    rem_q <= rem_d;
    mb_q  <= mb_d;
    cnt_q <= cnt_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;
  assign mag_o  = acc_q[RADW-1:0];

`ifndef ASSERT_OFF
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> state_q == A_IDLE)
    else $error("unit started while busy");

  a_fin_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == A_FIN |=> done_q)
    else $error("finish without done");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("done longer than one cycle");

  a_sqrt_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && op_q == OP_SQRT |-> !res_q[VAL_W-1])
    else $error("negative root");
`endif

endmodule

>>> hw/rtl/aleg_seq.sv
// sequencer: walks the legendre recurrence through the shared unit
module aleg_seq import aleg_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [BAND_W-1:0]           degree_i,
  input  logic [BAND_W-1:0]           order_i,
  input  logic signed [ARG_W-1:0]     arg_x_i,
  output logic                        res_valid_o,
  input  logic                        res_take_i,
  output logic signed [VAL_W-1:0]     res_value_o,
  output logic                        res_ok_o,
  output alu_req_t                    alu_req_o,
  output logic signed [OPA_W-1:0]     alu_a_o,
  output logic signed [FRAC_BITS+1:0] alu_b_o,
  output logic [2*FRAC_BITS+1:0]      alu_rad_o,
  input  logic                        alu_done_i,
  input  logic signed [VAL_W-1:0]     alu_res_i,
  input  logic [2*FRAC_BITS+1:0]      alu_mag_i
);

  localparam int MBW  = FRAC_BITS + 2;
  localparam int RADW = 2 * FRAC_BITS + 2;
  localparam int XCW  = (MBW > ARG_W) ? MBW : ARG_W;

  localparam logic signed [XCW-1:0]   ONE_X = XCW'(longint'(1) << FRAC_BITS);
  localparam logic signed [OPA_W-1:0] ONE_P = OPA_W'(longint'(1) << FRAC_BITS);
  localparam logic [RADW-1:0]         ONE2  = RADW'(1) << (2 * FRAC_BITS);

  seq_state_e state_q, state_d;
  logic issue_q, issue_d;

  logic [BAND_W-1:0] l_q, l_d, m_q, m_d, ll_q, ll_d, mcnt_q, mcnt_d;
  logic [3:0] fact_q, fact_d;
  logic signed [MBW-1:0]   x_q, x_d, s_q, s_d;
  logic [RADW-1:0]         rad_q, rad_d;
  logic signed [OPA_W-1:0] pmm_q, pmm_d, diff_q, diff_d;
  logic signed [VAL_W-1:0] pmm1_q, pmm1_d, t_q, t_d, val_q, val_d;
  logic ok_q, ok_d;

  logic [BAND_W-1:0] deg_c, ord_c;
  logic signed [XCW-1:0] x_ext, x_cl;
  logic signed [OPA_W-1:0] res_ext, pmm_neg, t_ext, pmm1_ext, x_wide;
  logic alu_busy, lm_eq, l_next, mm_last;
  logic [3:0] k_small;

  assign deg_c = (int'(degree_i) > MAX_BAND) ? BAND_W'(MAX_BAND) : degree_i;
  assign ord_c = (int'(order_i) > MAX_BAND) ? BAND_W'(MAX_BAND) : order_i;

  // argument beyond plus or minus one saturates to plus or minus one
  assign x_ext = XCW'(arg_x_i);
  assign x_cl  = (x_ext > ONE_X) ? ONE_X : ((x_ext < -ONE_X) ? -ONE_X : x_ext);

  assign res_ext  = {{(OPA_W-VAL_W){alu_res_i[VAL_W-1]}}, alu_res_i};
  assign pmm_neg  = -res_ext;
  assign t_ext    = {{(OPA_W-VAL_W){t_q[VAL_W-1]}}, t_q};
  assign pmm1_ext = {{(OPA_W-VAL_W){pmm1_q[VAL_W-1]}}, pmm1_q};
  assign x_wide   = {{(OPA_W-MBW){x_q[MBW-1]}}, x_q};

  assign alu_busy = (state_q != S_IDLE) && (state_q != S_OUT);
  assign lm_eq    = (l_q == m_q);
  assign l_next   = ({1'b0, l_q} == ({1'b0, m_q} + 4'd1));
  assign mm_last  = (mcnt_q == BAND_W'(1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = (ord_c > deg_c) ? S_OUT : S_SQR;
      end
      S_SQR: begin
        if (alu_done_i) state_d = S_SQRT;
      end
      S_SQRT: begin
        if (alu_done_i) begin
          if (m_q != '0) state_d = S_MM_RAW;
          else           state_d = lm_eq ? S_OUT : S_M1_RAW;
        end
      end
      S_MM_RAW: begin
        if (alu_done_i) state_d = S_MM_Q;
      end
      S_MM_Q: begin
        if (alu_done_i) begin
          if (!mm_last) state_d = S_MM_RAW;
          else          state_d = lm_eq ? S_OUT : S_M1_RAW;
        end
      end
      S_M1_RAW: begin
        if (alu_done_i) state_d = S_M1_Q;
      end
      S_M1_Q: begin
        if (alu_done_i) state_d = l_next ? S_OUT : S_RC_A1;
      end
      S_RC_A1: begin
        if (alu_done_i) state_d = S_RC_A2;
      end
      S_RC_A2: begin
        if (alu_done_i) state_d = S_RC_B;
      end
      S_RC_B: begin
        if (alu_done_i) state_d = S_RC_DIV;
      end
      S_RC_DIV: begin
        if (alu_done_i) state_d = (ll_q == l_q) ? S_OUT : S_RC_A1;
      end
      S_OUT: begin
        if (res_take_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o      = (state_q == S_IDLE);
    res_valid_o     = (state_q == S_OUT);
    alu_req_o.start = alu_busy && !issue_q;
    alu_req_o.op    = OP_MUL_RAW;
    alu_a_o         = pmm_q;
    alu_b_o         = x_q;
    alu_rad_o       = rad_q;
    k_small         = '0;
    unique case (state_q)
      S_SQR: begin
        alu_a_o = x_wide;
      end
      S_SQRT: begin
        alu_req_o.op = OP_SQRT;
      end
      S_MM_RAW: begin
        alu_b_o = MBW'(fact_q);
      end
      S_MM_Q: begin
        alu_req_o.op = OP_MUL_Q;
        alu_a_o      = t_ext;
        alu_b_o      = s_q;
      end
      S_M1_RAW: begin
        k_small = {m_q, 1'b1};
        alu_b_o = MBW'(k_small);
      end
      S_M1_Q, S_RC_A2: begin
        alu_req_o.op = OP_MUL_Q;
        alu_a_o      = t_ext;
      end
      S_RC_A1: begin
        k_small = {ll_q, 1'b0} - 4'd1;
        alu_a_o = pmm1_ext;
        alu_b_o = MBW'(k_small);
      end
      S_RC_B: begin
        k_small = {1'b0, ll_q} + {1'b0, m_q} - 4'd1;
        alu_b_o = MBW'(k_small);
      end
      S_RC_DIV: begin
        k_small      = {1'b0, ll_q - m_q};
        alu_req_o.op = OP_DIV;
        alu_a_o      = diff_q;
        alu_b_o      = MBW'(k_small);
      end
      default: ;
    endcase
  end

  always_comb begin
    issue_d = alu_busy && !alu_done_i;
    l_d     = l_q;
    m_d     = m_q;
    ll_d    = ll_q;
    mcnt_d  = mcnt_q;
    fact_d  = fact_q;
    x_d     = x_q;
    s_d     = s_q;
    rad_d   = rad_q;
    pmm_d   = pmm_q;
    pmm1_d  = pmm1_q;
    diff_d  = diff_q;
    t_d     = t_q;
    val_d   = val_q;
    ok_d    = ok_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          l_d   = deg_c;
          m_d   = ord_c;
          x_d   = x_cl[MBW-1:0];
          ok_d  = !(ord_c > deg_c);
          val_d = '0;
        end
      end
      S_SQR: begin
        if (alu_done_i) rad_d = ONE2 - alu_mag_i;
      end
      S_SQRT: begin
        if (alu_done_i) begin
          s_d    = alu_res_i[MBW-1:0];
          pmm_d  = ONE_P;
          fact_d = 4'd1;
          mcnt_d = m_q;
          val_d  = ONE_P[VAL_W-1:0];
        end
      end
      S_MM_Q: begin
        if (alu_done_i) begin
          pmm_d  = pmm_neg;
          fact_d = fact_q + 4'd2;
          mcnt_d = mcnt_q - BAND_W'(1);
          val_d  = pmm_neg[VAL_W-1:0];
        end
      end
      S_MM_RAW, S_M1_RAW, S_RC_A1, S_RC_A2: begin
        if (alu_done_i) t_d = alu_res_i;
      end
      S_M1_Q: begin
        if (alu_done_i) begin
          pmm1_d = alu_res_i;
          ll_d   = m_q + BAND_W'(2);
          val_d  = alu_res_i;
        end
      end
      S_RC_B: begin
        if (alu_done_i) diff_d = t_ext - res_ext;
      end
      S_RC_DIV: begin
        if (alu_done_i) begin
          pmm_d  = pmm1_ext;
          pmm1_d = alu_res_i;
          ll_d   = ll_q + BAND_W'(1);
          val_d  = alu_res_i;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      issue_q <= 1'b0;
    end else begin
      state_q <= state_d;
      issue_q <= issue_d;
    end
  end

  always_ff @(posedge clk_i) begin
    l_q    <= l_d;
    m_q    <= m_d;
    ll_q   <= ll_d;
    mcnt_q <= mcnt_d;
    fact_q <= fact_d;
    x_q    <= x_d;
    s_q    <= s_d;
    rad_q  <= rad_d;
    pmm_q  <= pmm_d;
    pmm1_q <= pmm1_d;
    diff_q <= diff_d;
    t_q    <= t_d;
    val_q  <= val_d;
    ok_q   <= ok_d;
  end

  assign res_value_o = val_q;
  assign res_ok_o    = ok_q;

endmodule

>>> hw/rtl/associated_legendre_eval.sv
// top level of the associated legendre polynomial evaluator
// an order above the degree goes straight to the output, flagged invalid; otherwise P(m,m) is
//   built first, then P(m,m+1), then one recurrence step per further degree
// one item at a time: a new input is taken only once the previous result has left the sequencer
// reset: asynchronous, active low; clears sequencer, unit and output control, no clearing pass
module associated_legendre_eval import aleg_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input requests
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [23:0]       s_axis_tdata_i,   // degree[2:0], order[5:3], arg_x[23:6]
  // result requests
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [VAL_W-1:0]  m_axis_tdata_o,   // poly_value[39:0]
  output logic [0:0]        m_axis_tuser_o    // valid_res[0]
);

  localparam int MBW  = FRAC_BITS + 2;
  localparam int RADW = 2 * FRAC_BITS + 2;

  // sequencer to shared unit
  alu_req_t                alu_req;
  logic signed [OPA_W-1:0] alu_a;
  logic signed [MBW-1:0]   alu_b;
  logic [RADW-1:0]         alu_rad;
  logic                    alu_done;
  logic signed [VAL_W-1:0] alu_res;
  logic [RADW-1:0]         alu_mag;

  // finished result from the sequencer
  logic                    res_valid;
  logic                    res_take;
  logic signed [VAL_W-1:0] res_value;
  logic                    res_ok;

  // output register
  logic             m_valid_q;
  logic [VAL_W-1:0] m_data_q;
  logic             m_ok_q;

  aleg_seq #(
    .FRAC_BITS (FRAC_BITS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .degree_i    (s_axis_tdata_i[2:0]),
    .order_i     (s_axis_tdata_i[5:3]),
    .arg_x_i     (s_axis_tdata_i[23:6]),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_value_o (res_value),
    .res_ok_o    (res_ok),
    .alu_req_o   (alu_req),
    .alu_a_o     (alu_a),
    .alu_b_o     (alu_b),
    .alu_rad_o   (alu_rad),
    .alu_done_i  (alu_done),
    .alu_res_i   (alu_res),
    .alu_mag_i   (alu_mag)
  );

  aleg_unit #(
    .FRAC_BITS (FRAC_BITS)
  ) u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .rad_i  (alu_rad),
    .done_o (alu_done),
    .res_o  (alu_res),
    .mag_o  (alu_mag)
  );

  // result moves on when the output register is empty or being drained
  assign res_take = res_valid && (!m_valid_q || m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_take) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  // payload carries no reset
  always_ff @(posedge clk_i) begin
    if (res_take) begin
      m_data_q <= res_value;
      m_ok_q   <= res_ok;
    end
  end

  assign m_axis_tvalid_o   = m_valid_q;
  assign m_axis_tdata_o    = m_data_q;
  assign m_axis_tuser_o[0] = m_ok_q;

`ifndef ASSERT_OFF
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |-> m_axis_tdata_o == '0)
    else $error("invalid result not zero");
`endif

endmodule
